FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge while out of reset.
`define PLHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define PLHP_ASSERT_IMPL(lbl, pre, post, msg) \
  `PLHP_ASSERT(lbl, (pre) |-> (post), msg)

`endif

FILE: hdl/plhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plhp_pkg;

  localparam int TEMP_W     = 16;
  localparam int DIFF_W     = TEMP_W + 1;
  localparam int LVL_W      = 7;
  localparam int QUO_W      = LVL_W;
  localparam int PROD_W     = LVL_W + TEMP_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int ACT_W      = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LVL_W-1:0] LEVEL_FULL_ON  = 7'd98;
  localparam logic [LVL_W-1:0] LEVEL_FULL_OFF = 7'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_START  = 2'd2,
    ACT_STOP   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_DELTA_LOW  = 3'd1,
    REG_LEVEL_LOW  = 3'd2,
    REG_DELTA_HIGH = 3'd3,
    REG_LEVEL_HIGH = 3'd4
  } reg_idx_e;

  // Classified command handed from front to back.
  typedef enum logic [2:0] {
    OP_SET_LOW,
    OP_SET_HIGH,
    OP_INTERP,
    OP_TICK,
    OP_START,
    OP_STOP
  } op_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic signed [TEMP_W-1:0] delta_low;
    logic        [LVL_W-1:0]  level_low;
    logic signed [TEMP_W-1:0] delta_high;
    logic        [LVL_W-1:0]  level_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    setpoint:   16'sh0000,
    delta_low:  16'shFFF0,
    level_low:  7'd100,
    delta_high: 16'sh0010,
    level_high: 7'd0
  };

  // offset: d - delta_low, only meaningful for OP_INTERP
  typedef struct packed {
    op_e               op;
    logic [TEMP_W-1:0] offset;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/plhp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module plhp_front
  import plhp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              push_i,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [TEMP_W-1:0] temperature_i,
  output logic                   full_o,
  output cmd_t                   cmd_o,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_take_i
);

  logic signed [DIFF_W-1:0] diff, dlo, dhi, off_full;
  cmd_t                     cmd_in;
  logic                     wr_en;

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  // Classify: d = temperature - setpoint, checked against both break points.
  always_comb begin
    diff     = {temperature_i[TEMP_W-1], temperature_i} -
               {cfg_i.setpoint[TEMP_W-1], cfg_i.setpoint};
    dlo      = {cfg_i.delta_low[TEMP_W-1], cfg_i.delta_low};
    dhi      = {cfg_i.delta_high[TEMP_W-1], cfg_i.delta_high};
    off_full = diff - dlo;
    cmd_in.offset = off_full[TEMP_W-1:0];
    case (action_e'(action_i))
      ACT_SAMPLE: begin
        if (diff <= dlo) begin
          cmd_in.op = OP_SET_LOW;
        end else if (diff >= dhi) begin
          cmd_in.op = OP_SET_HIGH;
        end else begin
          cmd_in.op = OP_INTERP;
        end
      end
      ACT_TICK:  cmd_in.op = OP_TICK;
      ACT_START: cmd_in.op = OP_START;
      ACT_STOP:  cmd_in.op = OP_STOP;
      default:   cmd_in.op = OP_STOP;
    endcase
  end

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (cmd_take_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !cmd_take_i) begin
        count_q <= count_q + 1'b1;
      end else if (!wr_en && cmd_take_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/plhp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module plhp_back
  import plhp_pkg::*;
#(
  parameter int PERIOD_TOP = 100
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire cmd_t             cmd_i,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_take_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output logic                  pin_out_o,
  output logic [LVL_W-1:0]      duty_report_o,
  output logic                  is_running_o,
  output logic [LVL_W-1:0]      phase_o
);

  localparam int PH_W  = $clog2(PERIOD_TOP + 1);
  localparam int CMP_W = (PH_W + 1 > LVL_W) ? PH_W + 1 : LVL_W;
  localparam int CNT_W = $clog2(QUO_W);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_e;

  state_e            state_q, state_d;
  logic              running_q, running_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [LVL_W-1:0]  duty_q, duty_d;
  logic              pin_q, pin_d;
  logic [CNT_W-1:0]  cnt_q;

  logic              out_valid_q;
  logic              out_pin_q, out_run_q;
  logic [LVL_W-1:0]  out_duty_q, out_phase_q;

  // divider datapath
  logic              neg_q;
  logic [LVL_W-1:0]  span_abs_q;
  logic [TEMP_W-1:0] offset_q, den_q, rem_q;
  logic [QUO_W-1:0]  low_q, quo_q;

  logic              slot_free, load, take;
  logic [PH_W:0]     phase_inc;
  logic [PH_W-1:0]   tick_phase;
  logic              tick_pin;
  logic [TEMP_W:0]   trial;
  logic              ge;
  logic [TEMP_W-1:0] rem_next;
  logic [LVL_W:0]    lvl_sum, span;
  logic signed [DIFF_W-1:0] dlo, dhi, den_full;
  logic [PROD_W-1:0] prod;

  assign slot_free  = !out_valid_q || pop_i;
  assign cmd_take_o = take;

  always_comb begin
    phase_inc  = (PH_W + 1)'(phase_q) + 1'b1;
    tick_phase = (phase_inc > (PH_W + 1)'(PERIOD_TOP)) ? '0 : phase_inc[PH_W-1:0];
    if (!running_q) begin
      tick_pin = 1'b0;
    end else if (duty_q >= LEVEL_FULL_ON) begin
      tick_pin = 1'b1;
    end else if (duty_q <= LEVEL_FULL_OFF) begin
      tick_pin = 1'b0;
    end else begin
      tick_pin = CMP_W'(tick_phase) < CMP_W'(duty_q);
    end

    // restoring divide, one quotient bit per cycle
    trial    = {rem_q, low_q[QUO_W-1]};
    ge       = trial >= {1'b0, den_q};
    rem_next = ge ? TEMP_W'(trial - {1'b0, den_q}) : trial[TEMP_W-1:0];

    // floor toward minus infinity: round the magnitude up when negative
    if (neg_q) begin
      lvl_sum = {1'b0, cfg_i.level_low} - {1'b0, quo_q} - (LVL_W + 1)'(rem_q != '0);
    end else begin
      lvl_sum = {1'b0, cfg_i.level_low} + {1'b0, quo_q};
    end

    span     = {1'b0, cfg_i.level_high} - {1'b0, cfg_i.level_low};
    dlo      = {cfg_i.delta_low[TEMP_W-1], cfg_i.delta_low};
    dhi      = {cfg_i.delta_high[TEMP_W-1], cfg_i.delta_high};
    den_full = dhi - dlo;
    prod     = PROD_W'(span_abs_q) * PROD_W'(offset_q);
  end

  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    phase_d   = phase_q;
    duty_d    = duty_q;
    pin_d     = pin_q;
    load      = 1'b0;
    take      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          take = 1'b1;
          case (cmd_i.op)
            OP_SET_LOW: begin
              duty_d = cfg_i.level_low;
              load   = 1'b1;
            end
            OP_SET_HIGH: begin
              duty_d = cfg_i.level_high;
              load   = 1'b1;
            end
            OP_INTERP: state_d = S_MUL;
            OP_TICK: begin
              phase_d = tick_phase;
              pin_d   = tick_pin;
              load    = 1'b1;
            end
            OP_START: begin
              if (!running_q) begin
                phase_d   = '0;
                running_d = 1'b1;
              end
              load = 1'b1;
            end
            OP_STOP: begin
              running_d = 1'b0;
              phase_d   = '0;
              pin_d     = 1'b0;
              load      = 1'b1;
            end
            default: load = 1'b1;
          endcase
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          duty_d  = lvl_sum[LVL_W-1:0];
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      phase_q     <= '0;
      duty_q      <= '0;
      pin_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      phase_q   <= phase_d;
      duty_q    <= duty_d;
      pin_q     <= pin_d;
      if (state_q == S_MUL) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pin_q   <= pin_d;
      out_run_q   <= running_d;
      out_duty_q  <= running_d ? duty_d : '0;
      out_phase_q <= LVL_W'(phase_d);
    end
    case (state_q)
      S_IDLE: begin
        if (take && cmd_i.op == OP_INTERP) begin
          offset_q   <= cmd_i.offset;
          den_q      <= den_full[TEMP_W-1:0];
          neg_q      <= span[LVL_W];
          span_abs_q <= span[LVL_W] ? LVL_W'(-span) : span[LVL_W-1:0];
        end
      end
      S_MUL: begin
        // product < 128 * divisor, so the top bits already sit below it
        rem_q <= prod[PROD_W-1:QUO_W];
        low_q <= prod[QUO_W-1:0];
      end
      S_DIV: begin
        rem_q <= rem_next;
        low_q <= {low_q[QUO_W-2:0], 1'b0};
        quo_q <= {quo_q[QUO_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign empty_o       = !out_valid_q;
  assign pin_out_o     = out_pin_q;
  assign duty_report_o = out_duty_q;
  assign is_running_o  = out_run_q;
  assign phase_o       = out_phase_q;

endmodule

`default_nettype wire

FILE: hdl/piecewise_linear_heater_pwm.sv
// Heater controller: proportional band on temperature samples, software PWM on ticks.
// Input channel (queue style): drive action_i/temperature_i with push_i; a transaction
//   completes on a clock edge with push_i high and full_o low. Actions are sample,
//   tick, start and stop; temperature_i matters only for samples.
// Result channel: every input transaction yields exactly one result, in order. While
//   empty_o is low the oldest result sits on pin_out_o, duty_report_o, is_running_o
//   and phase_o; pop_i with empty_o low takes it.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 setpoint,
//   1 delta_low, 2 level_low, 3 delta_high, 4 level_high). Write only while idle.
// Path: ticks, start, stop and clamped samples pass from the command queue into the
//   output register when the back end takes them. Samples inside the band go through
//   the take cycle, a multiply step, a restoring divider (one quotient bit per cycle)
//   and a finishing step that waits for a free output slot.
// Throughput: one item per cycle while the output slot is free, for everything but
//   in-band samples, which hold the back end until their result is loaded.
// A two-entry command queue sits between front and back, so input keeps flowing while
//   a result waits in the output register. When pop_i stays low the back end stops
//   after that result and the queue fills, then full_o rises.
// Reset clears run state, counter, duty level and pin, empties both queues and loads
//   the register defaults (setpoint 0, break points -16/+16, levels 100/0).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module piecewise_linear_heater_pwm
  import plhp_pkg::*;
#(
  parameter int PERIOD_TOP = 100
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [ACT_W-1:0]      action_i,
  input  wire logic [TEMP_W-1:0]     temperature_i,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output logic                       pin_out_o,
  output logic [LVL_W-1:0]           duty_report_o,
  output logic                       is_running_o,
  output logic [LVL_W-1:0]           phase_o
);

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  logic cmd_valid, cmd_take;

  // Register file, write only.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SETPOINT:   cfg_d.setpoint   = cfg_wdata_i;
        REG_DELTA_LOW:  cfg_d.delta_low  = cfg_wdata_i;
        REG_LEVEL_LOW:  cfg_d.level_low  = cfg_wdata_i[LVL_W-1:0];
        REG_DELTA_HIGH: cfg_d.delta_high = cfg_wdata_i;
        REG_LEVEL_HIGH: cfg_d.level_high = cfg_wdata_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify samples against the band, queue commands.
  plhp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push_i),
    .action_i      (action_i),
    .temperature_i (temperature_i),
    .full_o        (full_o),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_take_i    (cmd_take)
  );

  // Back: execute commands, interpolate, run the PWM counter, hold the result.
  plhp_back #(
    .PERIOD_TOP (PERIOD_TOP)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .cmd_take_o    (cmd_take),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .pin_out_o     (pin_out_o),
    .duty_report_o (duty_report_o),
    .is_running_o  (is_running_o),
    .phase_o       (phase_o)
  );

  // Back end must never pull from an empty command queue.
  `PLHP_ASSERT_IMPL(a_take_needs_cmd, cmd_take, cmd_valid, "back took from empty queue")
  // Pin is only ever driven high while modulation runs.
  `PLHP_ASSERT_IMPL(a_pin_low_stopped, !empty_o && !is_running_o, !pin_out_o,
                    "pin high while stopped")
  // Duty report reads zero whenever stopped.
  `PLHP_ASSERT_IMPL(a_duty_zero_stopped, !empty_o && !is_running_o, duty_report_o == '0,
                    "duty reported while stopped")

endmodule

`default_nettype wire
